// File: src/hcm_pkg.sv
// Shared types and constants for the headphone crossfeed mixer.
package hcm_pkg;

	localparam int COEF_W     = 16;
	localparam int DLEN_W     = 6;
	localparam int FADE_W     = 17;
	localparam int MIX_W      = 17;
	localparam int MULB_W     = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [MIX_W-1:0] MIX_ONE = 17'h10000;

	localparam logic [COEF_W-1:0] DIRECT_GAIN_RST   = 16'd41071;
	localparam logic [COEF_W-1:0] CROSS_GAIN_RST    = 16'd24465;
	localparam logic [COEF_W-1:0] LOWPASS_COEFF_RST = 16'd59795;
	localparam logic [DLEN_W-1:0] DELAY_LENGTH_RST  = 6'd14;
	localparam logic [FADE_W-1:0] RAMP_STEP_RST     = 17'd7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE        = 3'd0,
		REG_DIRECT_GAIN   = 3'd1,
		REG_CROSS_GAIN    = 3'd2,
		REG_LOWPASS_COEFF = 3'd3,
		REG_DELAY_LENGTH  = 3'd4,
		REG_RAMP_STEP     = 3'd5
	} cfg_reg_t;

	// accumulator control for the shared multiply-accumulate unit
	typedef struct packed {
		logic acc_load;
		logic acc_add;
	} mac_ctrl_t;

endpackage

// File: src/hcm_ifs.sv
// Stream and configuration interfaces of the headphone crossfeed mixer.
interface hcm_in_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;
	logic                          block_end;

	modport source (output valid, left_in, right_in, block_end, input ready);
	modport sink (input valid, left_in, right_in, block_end, output ready);
endinterface

interface hcm_out_if #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

interface hcm_cfg_if import hcm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/hcm_mac.sv
// Shared signed multiplier with registered product and accumulator.
module hcm_mac import hcm_pkg::*; #(
	parameter int A_W = 26,
	parameter int B_W = 18
) (
	input  logic                        clk,
	input  logic signed [A_W-1:0]       op_a,
	input  logic signed [B_W-1:0]       op_b,
	input  mac_ctrl_t                   ctrl,
	output logic signed [A_W+B_W:0]     acc
);

	logic signed [A_W+B_W-1:0] prod_s1;
	logic signed [A_W+B_W:0]   acc_q;
	logic signed [A_W+B_W:0]   prod_ext;

	assign prod_ext = {prod_s1[A_W+B_W-1], prod_s1};

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		if (ctrl.acc_load) begin
			acc_q <= prod_ext;
		end else if (ctrl.acc_add) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	assign acc = acc_q;

endmodule

// File: src/headphone_crossfeed_mixer_core.sv
// Top level of the headphone crossfeed mixer: sequencer, delay memory, config.
//
// Stereo crossfeed for headphones. Each frame item (signed Q1.SAMPLE_BITS-1)
// runs both channels through a one-pole low-pass, stores the filtered pair
// in a DELAY_DEPTH-deep delay memory, and mixes the delayed, filtered
// opposite side into each channel with direct_gain and cross_gain. The
// output is a dry/wet blend whose Q1.16 mix factor ramps by the ramp step per
// frame toward enable, saturated to the sample range. A 0->1 write of
// enable restarts the filters, delays and mix on the next active frame and
// passes delay_length frames dry while the delay fills. With enable low
// and the mix faded out, frames pass straight through. A block_end frame
// with the mix at zero clears filters and delays. All ten products of a
// frame go through one shared multiply-accumulate unit under a step
// sequencer that works on one frame at a time; frames.ready is high only
// while the sequencer is idle. Results sit in an output register, so a new
// frame is accepted while the previous result waits on mixed.ready; the
// next frame then holds in its last step until that result is taken.
// Delay entries carry a valid bit each, so clears take effect at once and
// there is no clearing pass after reset. The config port is always ready;
// write it only while no frame is in flight.
module headphone_crossfeed_mixer_core import hcm_pkg::*; #(
	parameter int DELAY_DEPTH = 64,
	parameter int SAMPLE_BITS = 24
) (
	input  logic  clk,
	input  logic  arst_n,
	hcm_in_if.sink    frames,
	hcm_out_if.source mixed,
	hcm_cfg_if.sink   cfg
);

	localparam int SB    = SAMPLE_BITS;
	localparam int AW    = $clog2(DELAY_DEPTH);
	localparam int A_W   = SB + 2;
	localparam int B_W   = MULB_W;
	localparam int ACC_W = A_W + B_W + 1;
	localparam int TW    = ((AW > DLEN_W) ? AW : DLEN_W) + 1;

	typedef enum logic [4:0] {
		S_IDLE, S_CTRL, S_ADDR,
		S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
		S_M7, S_M8, S_M9, S_M10, S_M11, S_M12,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic              enable_q;
	logic [COEF_W-1:0] direct_gain_q;
	logic [COEF_W-1:0] cross_gain_q;
	logic [COEF_W-1:0] lowpass_coeff_q;
	logic [DLEN_W-1:0] delay_length_q;
	logic [FADE_W-1:0] ramp_step_q;

	// processing state
	logic                 restart_q;
	logic [MIX_W-1:0]     mix_q;
	logic [DLEN_W-1:0]    prefill_q;
	logic [AW-1:0]        wp_q;
	logic [DELAY_DEPTH-1:0] valid_q;
	logic signed [SB-1:0] filt_l_q;
	logic signed [SB-1:0] filt_r_q;
	logic                 out_valid_q;

	// per-item payload
	logic signed [SB-1:0]  x_l_q;
	logic signed [SB-1:0]  x_r_q;
	logic                  last_q;
	logic                  dry_q;
	logic signed [SB+1:0]  diff_l_q;
	logic signed [SB+1:0]  diff_r_q;
	logic signed [SB-1:0]  bl_l_q;
	logic signed [SB-1:0]  bl_r_q;
	logic signed [SB-1:0]  out_l_q;
	logic signed [SB-1:0]  out_r_q;

	// delay memory: left filtered sample in the upper half, right in the lower
	logic [2*SB-1:0] mem [DELAY_DEPTH];
	logic [2*SB-1:0] rd_data_q;
	logic            rd_valid_q;
	logic [AW-1:0]   rd_addr;

	logic signed [A_W-1:0]   op_a;
	logic signed [B_W-1:0]   op_b;
	mac_ctrl_t               mac_ctrl;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [ACC_W-1:0] rnd;

	logic signed [SB-1:0] d_l;
	logic signed [SB-1:0] d_r;
	logic [MIX_W-1:0]     inv_a;
	logic                 active;
	logic                 in_fire;
	logic                 cfg_fire;
	logic                 out_fire;
	logic                 done_fire;
	logic [MIX_W:0]       mix_up;
	logic [AW-1:0]        wp_next;

	function automatic logic [AW-1:0] dlen_mod(input logic [DLEN_W-1:0] v);
		logic [TW-1:0] t;
		t = TW'(v);
		for (int i = 0; i < 8; i++) begin
			if (t >= TW'(DELAY_DEPTH)) begin
				t = t - TW'(DELAY_DEPTH);
			end
		end
		return t[AW-1:0];
	endfunction

	function automatic logic signed [SB-1:0] sat(input logic signed [SB+2:0] v);
		logic signed [SB-1:0] r;
		if ((v[SB+2:SB-1] == '0) || (v[SB+2:SB-1] == '1)) begin
			r = v[SB-1:0];
		end else if (v[SB+2]) begin
			r = {1'b1, {(SB-1){1'b0}}};
		end else begin
			r = {1'b0, {(SB-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [A_W-1:0] sx(input logic signed [SB-1:0] v);
		return {{2{v[SB-1]}}, v};
	endfunction

	assign frames.ready = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign mixed.valid  = out_valid_q;
	assign mixed.left_out  = out_l_q;
	assign mixed.right_out = out_r_q;

	assign in_fire   = frames.valid && frames.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign out_fire  = out_valid_q && mixed.ready;
	assign done_fire = (state_q == S_DONE) && (!out_valid_q || mixed.ready);
	assign active    = enable_q || (mix_q != '0);

	assign inv_a   = MIX_ONE - {1'b0, lowpass_coeff_q};
	assign mix_up  = {1'b0, mix_q} + {1'b0, ramp_step_q};
	assign wp_next = (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + 1'b1;

	// read slot lags the write pointer by delay_length modulo the depth
	always_comb begin
		logic [AW:0] t;
		t = {1'b0, wp_q} + (AW+1)'(DELAY_DEPTH) - {1'b0, dlen_mod(delay_length_q)};
		if (t >= (AW+1)'(DELAY_DEPTH)) begin
			t = t - (AW+1)'(DELAY_DEPTH);
		end
		rd_addr = t[AW-1:0];
	end

	// entries never written since the last clear read as zero
	assign d_l = rd_valid_q ? rd_data_q[2*SB-1:SB] : '0;
	assign d_r = rd_valid_q ? rd_data_q[SB-1:0] : '0;

	// operand schedule: product issued in step k is accumulated in step k+1
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_M0:  begin op_a = sx(x_l_q);    op_b = {1'b0, inv_a}; end
			S_M1:  begin op_a = sx(filt_l_q); op_b = B_W'(lowpass_coeff_q); end
			S_M2:  begin op_a = sx(x_r_q);    op_b = {1'b0, inv_a}; end
			S_M3:  begin op_a = sx(filt_r_q); op_b = B_W'(lowpass_coeff_q); end
			S_M4:  begin op_a = sx(x_l_q);    op_b = B_W'(direct_gain_q); end
			S_M5:  begin op_a = sx(d_r);      op_b = B_W'(cross_gain_q); end
			S_M6:  begin op_a = sx(x_r_q);    op_b = B_W'(direct_gain_q); end
			S_M7:  begin op_a = sx(d_l);      op_b = B_W'(cross_gain_q); end
			S_M8:  begin op_a = diff_l_q;     op_b = {1'b0, mix_q}; end
			S_M10: begin op_a = diff_r_q;     op_b = {1'b0, mix_q}; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	always_comb begin
		mac_ctrl = '0;
		case (state_q)
			S_M1, S_M3, S_M5, S_M7, S_M9, S_M11: mac_ctrl.acc_load = 1'b1;
			S_M2, S_M4, S_M6, S_M8:              mac_ctrl.acc_add  = 1'b1;
			default: mac_ctrl = '0;
		endcase
	end

	hcm_mac #(
		.A_W (A_W),
		.B_W (B_W)
	) u_mac (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.ctrl (mac_ctrl),
		.acc  (acc)
	);

	// round half up, floor shift by 16
	assign acc_rnd = acc + ACC_W'(32768);
	assign rnd     = acc_rnd >>> 16;

	// sequencer, configuration and processing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			enable_q        <= 1'b0;
			direct_gain_q   <= DIRECT_GAIN_RST;
			cross_gain_q    <= CROSS_GAIN_RST;
			lowpass_coeff_q <= LOWPASS_COEFF_RST;
			delay_length_q  <= DELAY_LENGTH_RST;
			ramp_step_q     <= RAMP_STEP_RST;
			restart_q       <= 1'b0;
			mix_q           <= '0;
			prefill_q       <= '0;
			wp_q            <= '0;
			valid_q         <= '0;
			filt_l_q        <= '0;
			filt_r_q        <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_fire) begin
				case (cfg_reg_t'(cfg.index))
					REG_ENABLE: begin
						if (cfg.data[0] && !enable_q) begin
							restart_q <= 1'b1;
						end
						enable_q <= cfg.data[0];
					end
					REG_DIRECT_GAIN:   direct_gain_q   <= cfg.data[COEF_W-1:0];
					REG_CROSS_GAIN:    cross_gain_q    <= cfg.data[COEF_W-1:0];
					REG_LOWPASS_COEFF: lowpass_coeff_q <= cfg.data[COEF_W-1:0];
					REG_DELAY_LENGTH:  delay_length_q  <= cfg.data[DLEN_W-1:0];
					REG_RAMP_STEP:     ramp_step_q     <= cfg.data[FADE_W-1:0];
					default: ;
				endcase
			end

			// a finishing item refills the output slot as the old result leaves
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_CTRL;
					end
				end
				S_CTRL: begin
					if (active) begin
						if (restart_q) begin
							filt_l_q  <= '0;
							filt_r_q  <= '0;
							valid_q   <= '0;
							wp_q      <= '0;
							mix_q     <= '0;
							prefill_q <= delay_length_q;
							restart_q <= 1'b0;
						end
						state_q <= S_ADDR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_ADDR: begin
					if (prefill_q != '0) begin
						prefill_q <= prefill_q - 1'b1;
					end else if (enable_q) begin
						mix_q <= (mix_up > {1'b0, MIX_ONE}) ? MIX_ONE : mix_up[MIX_W-1:0];
					end else begin
						mix_q <= (mix_q > ramp_step_q) ? mix_q - ramp_step_q : '0;
					end
					state_q <= S_M0;
				end
				S_M3: begin
					filt_l_q <= rnd[SB-1:0];
					state_q  <= S_M4;
				end
				S_M5: begin
					filt_r_q <= rnd[SB-1:0];
					state_q  <= S_M6;
				end
				S_M6: begin
					valid_q[wp_q] <= 1'b1;
					wp_q          <= wp_next;
					state_q       <= S_M7;
				end
				S_M12: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (done_fire) begin
						if (last_q && (mix_q == '0)) begin
							filt_l_q <= '0;
							filt_r_q <= '0;
							valid_q  <= '0;
							wp_q     <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_M0, S_M1, S_M2, S_M4, S_M7, S_M8, S_M9, S_M10, S_M11: begin
					state_q <= state_t'(state_q + 5'd1);
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and datapath results
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_l_q  <= frames.left_in;
			x_r_q  <= frames.right_in;
			last_q <= frames.block_end;
		end
		if ((state_q == S_CTRL) && !active) begin
			dry_q <= 1'b1;
		end
		if (state_q == S_ADDR) begin
			dry_q      <= (prefill_q != '0);
			rd_valid_q <= valid_q[rd_addr];
		end
		if (state_q == S_M7) begin
			diff_l_q <= {rnd[SB], rnd[SB:0]} - sx(x_l_q);
		end
		if (state_q == S_M9) begin
			diff_r_q <= {rnd[SB], rnd[SB:0]} - sx(x_r_q);
		end
		if (state_q == S_M10) begin
			bl_l_q <= sat({{3{x_l_q[SB-1]}}, x_l_q} + rnd[SB+2:0]);
		end
		if (state_q == S_M12) begin
			bl_r_q <= sat({{3{x_r_q[SB-1]}}, x_r_q} + rnd[SB+2:0]);
		end
		if (done_fire) begin
			out_l_q <= dry_q ? x_l_q : bl_l_q;
			out_r_q <= dry_q ? x_r_q : bl_r_q;
		end
	end

	// delay memory: read the tap before this frame's write
	always_ff @(posedge clk) begin
		if (state_q == S_ADDR) begin
			rd_data_q <= mem[rd_addr];
		end
		if (state_q == S_M6) begin
			mem[wp_q] <= {filt_l_q, filt_r_q};
		end
	end

	// write pointer stays inside the delay memory
	assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, wp_q} < (AW+1)'(DELAY_DEPTH))
	else $error("write pointer out of range");

	// mix factor never ramps past unity
	assert property (@(posedge clk) disable iff (!arst_n)
		mix_q <= MIX_ONE)
	else $error("mix factor above unity");

	// a result only appears when the sequencer finishes an item
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
	else $error("result raised outside of completion step");

	// a restart zeroes the mix before the ramp step
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CTRL && active && restart_q) |=> (mix_q == '0 && !restart_q))
	else $error("restart did not clear mix");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the headphone crossfeed mixer core.
module testbench;
	import hcm_pkg::*;

	localparam int SB          = 24;
	localparam int DEPTH       = 64;
	localparam int RANDOM_ITEMS = 1300;
	// Let the core's sequencer fall idle; give it margin before touching registers.
	localparam int SETTLE_CYCLES = 24;

	localparam logic signed [SB-1:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [SB-1:0] S_MIN = 24'sh800000;
	localparam longint SAT_HI = 64'sd8388607;
	localparam longint SAT_LO = -64'sd8388608;

	typedef struct {
		logic signed [SB-1:0] left_in;
		logic signed [SB-1:0] right_in;
		logic                 block_end;
	} frame_item_t;

	typedef struct {
		logic signed [SB-1:0] left_out;
		logic signed [SB-1:0] right_out;
	} mixed_frame_t;

	logic clk = 1'b0;
	logic arst_n;

	hcm_in_if  #(.SAMPLE_BITS(SB)) frames_if ();
	hcm_out_if #(.SAMPLE_BITS(SB)) mixed_if ();
	hcm_cfg_if                     cfg_if ();

	headphone_crossfeed_mixer_core #(
		.DELAY_DEPTH(DEPTH),
		.SAMPLE_BITS(SB)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frames (frames_if),
		.mixed  (mixed_if),
		.cfg    (cfg_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Crossfeed predictor: register copies and processing state
	// ------------------------------------------------------------------
	logic              cfg_en    = 1'b0;
	logic [COEF_W-1:0] cfg_dgain = DIRECT_GAIN_RST;
	logic [COEF_W-1:0] cfg_xgain = CROSS_GAIN_RST;
	logic [COEF_W-1:0] cfg_lpa   = LOWPASS_COEFF_RST;
	logic [DLEN_W-1:0] cfg_dlen  = DELAY_LENGTH_RST;
	logic [FADE_W-1:0] cfg_fstep = RAMP_STEP_RST;

	longint            filt_l = 0;
	longint            filt_r = 0;
	longint            dly_l [DEPTH];
	longint            dly_r [DEPTH];
	logic [DLEN_W-1:0] wr_ptr       = '0;
	logic [DLEN_W-1:0] prefill_left = '0;
	logic [MIX_W-1:0]  mix          = '0;
	logic              restart_pend = 1'b0;

	frame_item_t  pending_frames [$];
	mixed_frame_t results_due [$];

	int error_total     = 0;
	int frames_queued   = 0;
	int frames_accepted = 0;
	int frames_checked  = 0;
	int reg_writes      = 0;
	int settings_run    = 0;
	int restarts_seen   = 0;
	int full_wet_frames = 0;

	// floor(v / 65536 + 0.5) on signed values
	function automatic longint rnd16(longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic longint lowpass(longint x, longint y);
		longint a;
		a = longint'(cfg_lpa);
		return rnd16(x * (64'sd65536 - a) + y * a);
	endfunction

	function automatic longint blend(longint x, longint opp);
		longint wet;
		longint mixed_val;
		wet = rnd16(x * longint'(cfg_dgain) + opp * longint'(cfg_xgain));
		mixed_val = x + rnd16((wet - x) * longint'(mix));
		if (mixed_val > SAT_HI)
			mixed_val = SAT_HI;
		else if (mixed_val < SAT_LO)
			mixed_val = SAT_LO;
		return mixed_val;
	endfunction

	function automatic void clear_delays();
		filt_l = 0;
		filt_r = 0;
		for (int i = 0; i < DEPTH; i++) begin
			dly_l[i] = 0;
			dly_r[i] = 0;
		end
		wr_ptr = '0;
	endfunction

	function automatic mixed_frame_t predict_frame(frame_item_t f);
		longint            x_l;
		longint            x_r;
		int unsigned       mix_sum;
		logic [DLEN_W-1:0] rd;
		mixed_frame_t      res;
		x_l = longint'(f.left_in);
		x_r = longint'(f.right_in);
		res.left_out  = f.left_in;
		res.right_out = f.right_in;
		// bypass: disabled and fully faded out, frame passes dry
		if (cfg_en || mix != '0) begin
			if (restart_pend) begin
				clear_delays();
				mix = '0;
				prefill_left = cfg_dlen;
				restart_pend = 1'b0;
				restarts_seen++;
			end
			filt_l = lowpass(x_l, filt_l);
			filt_r = lowpass(x_r, filt_r);
			if (prefill_left != '0) begin
				// delay still filling: output stays dry, mix frozen
				prefill_left--;
			end else begin
				if (cfg_en) begin
					mix_sum = mix + cfg_fstep;
					mix = (mix_sum > MIX_ONE) ? MIX_ONE : MIX_W'(mix_sum);
				end else begin
					mix = (mix > cfg_fstep) ? MIX_W'(mix - cfg_fstep) : '0;
				end
				if (mix == MIX_ONE)
					full_wet_frames++;
				// 6-bit wrap does the modulo; zero length reads the slot about to be overwritten
				rd = wr_ptr - cfg_dlen;
				res.left_out  = SB'(blend(x_l, dly_r[rd]));
				res.right_out = SB'(blend(x_r, dly_l[rd]));
			end
			dly_l[wr_ptr] = filt_l;
			dly_r[wr_ptr] = filt_r;
			wr_ptr++;
		end
		if (f.block_end && mix == '0)
			clear_delays();
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic int draw_wait(bit quiet);
		return quiet ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic logic signed [SB-1:0] draw_sample();
		case ($urandom_range(0, 9))
			0: return S_MAX;
			1: return S_MIN;
			2: return '0;
			3: return '1;
			4, 5: return SB'($urandom_range(0, 2047)) - SB'(1024);
			default: return SB'($urandom());
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CFG_DATA_W'(16'hFFFF);
			default: return CFG_DATA_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic push_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
			input logic last);
		frame_item_t f;
		f.left_in   = l;
		f.right_in  = r;
		f.block_end = last;
		pending_frames.push_back(f);
		frames_queued++;
	endtask

	// one register write; the predictor copy follows at the accepting edge
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			REG_ENABLE: begin
				if (value[0] && !cfg_en)
					restart_pend = 1'b1;
				cfg_en = value[0];
			end
			REG_DIRECT_GAIN:   cfg_dgain = value[COEF_W-1:0];
			REG_CROSS_GAIN:    cfg_xgain = value[COEF_W-1:0];
			REG_LOWPASS_COEFF: cfg_lpa   = value[COEF_W-1:0];
			REG_DELAY_LENGTH:  cfg_dlen  = value[DLEN_W-1:0];
			REG_RAMP_STEP:     cfg_fstep = value[FADE_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// drain everything queued, then let the sequencer fall idle
	task automatic wait_idle();
		@(posedge clk);
		while (pending_frames.size() != 0 || frames_if.valid || results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		settings_run++;
	endtask

	// ------------------------------------------------------------------
	// Frame driver: accept at posedge, drive next item at negedge
	// ------------------------------------------------------------------
	bit          frame_taken = 1'b0;
	bit          send_quiet  = 1'b0;
	int          send_gap    = 0;
	frame_item_t next_frame;

	always @(posedge clk) begin
		if (arst_n && frames_if.valid && frames_if.ready) begin
			frame_taken = 1'b1;
			next_frame.left_in   = frames_if.left_in;
			next_frame.right_in  = frames_if.right_in;
			next_frame.block_end = frames_if.block_end;
			results_due.push_back(predict_frame(next_frame));
			frames_accepted++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!frames_if.valid || frame_taken)) begin
			frame_taken = 1'b0;
			if (send_gap > 0) begin
				frames_if.valid <= 1'b0;
				send_gap--;
			end else if (pending_frames.size() != 0) begin
				next_frame = pending_frames.pop_front();
				frames_if.valid     <= 1'b1;
				frames_if.left_in   <= next_frame.left_in;
				frames_if.right_in  <= next_frame.right_in;
				frames_if.block_end <= next_frame.block_end;
				// occasional switch between back-to-back bursts and gappy traffic
				if ($urandom_range(0, 47) == 0)
					send_quiet = !send_quiet;
				send_gap = draw_wait(send_quiet);
			end else begin
				frames_if.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor and receiver backpressure
	// ------------------------------------------------------------------
	bit           result_taken = 1'b0;
	bit           recv_quiet   = 1'b0;
	int           recv_stall   = 0;
	mixed_frame_t want;

	always @(posedge clk) begin
		if (arst_n && mixed_if.valid && mixed_if.ready) begin
			result_taken = 1'b1;
			if (results_due.size() == 0) begin
				$error("mixed item with no frame pending: left_out %0d right_out %0d",
					mixed_if.left_out, mixed_if.right_out);
				error_total++;
			end else begin
				want = results_due.pop_front();
				if (mixed_if.left_out !== want.left_out) begin
					$error("left_out mismatch: expected %0d, got %0d",
						want.left_out, mixed_if.left_out);
					error_total++;
				end
				if (mixed_if.right_out !== want.right_out) begin
					$error("right_out mismatch: expected %0d, got %0d",
						want.right_out, mixed_if.right_out);
					error_total++;
				end
				frames_checked++;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken) begin
				result_taken = 1'b0;
				if ($urandom_range(0, 47) == 0)
					recv_quiet = !recv_quiet;
				recv_stall = draw_wait(recv_quiet);
			end
			if (recv_stall > 0) begin
				mixed_if.ready <= 1'b0;
				recv_stall--;
			end else begin
				mixed_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned n_frames;
		int unsigned end_pct;
		arst_n              = 1'b0;
		frames_if.valid     = 1'b0;
		frames_if.left_in   = '0;
		frames_if.right_in  = '0;
		frames_if.block_end = 1'b0;
		mixed_if.ready      = 1'b0;
		cfg_if.valid        = 1'b0;
		cfg_if.index        = REG_ENABLE;
		cfg_if.data         = '0;
		for (int i = 0; i < DEPTH; i++) begin
			dly_l[i] = 0;
			dly_r[i] = 0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, crossfeed off: straight pass-through incl. block end
		push_frame(S_MAX, S_MIN, 1'b0);
		push_frame(S_MIN, S_MAX, 1'b1);
		push_frame('0, '1, 1'b0);
		push_frame(24'sh555555, 24'shAAAAAA, 1'b1);
		wait_idle();

		// full gains, transparent filter, zero delay, oversized fade step:
		// enable jumps the mix straight to one and the wet sum saturates
		write_reg(REG_DIRECT_GAIN, CFG_DATA_W'(16'hFFFF));
		write_reg(REG_CROSS_GAIN, CFG_DATA_W'(16'hFFFF));
		write_reg(REG_LOWPASS_COEFF, '0);
		write_reg(REG_DELAY_LENGTH, '0);
		write_reg(REG_RAMP_STEP, '1);
		write_reg(REG_ENABLE, CFG_DATA_W'(1));
		push_frame(S_MAX, S_MAX, 1'b0);
		push_frame(S_MIN, S_MIN, 1'b0);
		push_frame(S_MAX, S_MIN, 1'b0);
		push_frame(S_MIN, S_MAX, 1'b0);
		push_frame(24'sh400000, -24'sh400000, 1'b1);
		push_frame('1, '0, 1'b0);
		wait_idle();

		// restart with a short prefill and zero fade step: mix never leaves zero,
		// so the block end inside prefill clears the delay line
		write_reg(REG_DELAY_LENGTH, CFG_DATA_W'(3));
		write_reg(REG_RAMP_STEP, '0);
		write_reg(REG_ENABLE, '0);
		write_reg(REG_ENABLE, CFG_DATA_W'(1));
		push_frame(S_MAX, 24'sh123456, 1'b0);
		push_frame(S_MIN, -24'sh123456, 1'b1);
		push_frame(24'sh0F0F0F, S_MAX, 1'b0);
		push_frame(-24'sh0F0F0F, S_MIN, 1'b0);
		push_frame(24'sh000001, 24'shFFFFFF, 1'b0);
		wait_idle();

		// one-frame delay, frozen filter, unit fade: mix reaches one at once
		write_reg(REG_DELAY_LENGTH, CFG_DATA_W'(1));
		write_reg(REG_LOWPASS_COEFF, CFG_DATA_W'(16'hFFFF));
		write_reg(REG_RAMP_STEP, CFG_DATA_W'(MIX_ONE));
		write_reg(REG_ENABLE, '0);
		write_reg(REG_ENABLE, CFG_DATA_W'(1));
		push_frame(S_MAX, S_MIN, 1'b0);
		push_frame(24'sh3FFFFF, 24'sh7FFF00, 1'b0);
		push_frame(S_MIN, S_MAX, 1'b0);
		wait_idle();

		// disable: one fade step back to dry, then block end clears
		write_reg(REG_ENABLE, '0);
		push_frame(S_MAX, S_MAX, 1'b0);
		push_frame(S_MIN, 24'sh000100, 1'b1);
		push_frame(24'sh7F0000, S_MIN, 1'b0);
		wait_idle();

		// random settings, each run with a batch of random frames
		n_frames = frames_queued + RANDOM_ITEMS;
		while (frames_queued < n_frames) begin
			if ($urandom_range(0, 1))
				write_reg(REG_DIRECT_GAIN, pick_gain());
			if ($urandom_range(0, 1))
				write_reg(REG_CROSS_GAIN, pick_gain());
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_LOWPASS_COEFF, $urandom_range(0, 1) ? pick_gain() :
					CFG_DATA_W'($urandom_range(50000, 65535)));
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 4))
					0: write_reg(REG_DELAY_LENGTH, '0);
					1: write_reg(REG_DELAY_LENGTH, CFG_DATA_W'(1));
					2: write_reg(REG_DELAY_LENGTH, CFG_DATA_W'(63));
					default: write_reg(REG_DELAY_LENGTH, CFG_DATA_W'($urandom_range(1, 63)));
				endcase
			end
			if ($urandom_range(0, 1)) begin
				// mostly steps that finish a fade within a batch
				case ($urandom_range(0, 7))
					0: write_reg(REG_RAMP_STEP, '0);
					1: write_reg(REG_RAMP_STEP, CFG_DATA_W'(1));
					2: write_reg(REG_RAMP_STEP, CFG_DATA_W'(MIX_ONE));
					3: write_reg(REG_RAMP_STEP, '1);
					4: write_reg(REG_RAMP_STEP, CFG_DATA_W'($urandom_range(1, 131071)));
					default: write_reg(REG_RAMP_STEP, CFG_DATA_W'($urandom_range(256, 65536)));
				endcase
			end
			case ($urandom_range(0, 4))
				0: write_reg(REG_ENABLE, CFG_DATA_W'(1));
				1, 2: begin
					// toggle through zero to force a restart
					write_reg(REG_ENABLE, '0);
					write_reg(REG_ENABLE, CFG_DATA_W'(1));
				end
				3: write_reg(REG_ENABLE, '0);
				default: ;
			endcase
			end_pct = $urandom_range(0, 20);
			repeat ($urandom_range(20, 140))
				push_frame(draw_sample(), draw_sample(), $urandom_range(0, 99) < end_pct);
			wait_idle();
		end

		$display("Checked %0d of %0d accepted frames over %0d register settings (%0d writes)",
			frames_checked, frames_accepted, settings_run, reg_writes);
		$display("Restarts taken: %0d, frames at full crossfeed: %0d",
			restarts_seen, full_wet_frames);
		if (error_total == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog: a hung handshake ends the run as a failure
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
